@@ rtl/core/pcf_pkg.sv @@
// Shared types for the permutation tuple canonical form block.
// Holds function codes, datapath operation codes and the command/status structs.
// No dependencies.
`default_nettype none
package pcf_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_CANON = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,
    OP_READ    = 4'd2,
    OP_ICLR    = 4'd3,
    OP_IBLD    = 4'd4,
    OP_ROOT    = 4'd5,
    OP_QFETCH  = 4'd6,
    OP_STEP    = 4'd7,
    OP_RELABEL = 4'd8,
    OP_CMP     = 4'd9,
    OP_COPY    = 4'd10,
    OP_FINAL   = 4'd11,
    OP_RESP    = 4'd12
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic more;
    logic complete;
    logic take;
    logic last_root;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/pcf_ctrl.sv @@
// Controller state machine for the permutation tuple canonical form block.
// Sequences datapath operations; depends on pcf_pkg.
`default_nettype none
module pcf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_accept,
  input  wire logic [1:0]    in_func,
  input  wire pcf_pkg::sts_t sts,
  input  wire logic          out_tready,
  output pcf_pkg::cmd_t      cmd,
  output logic               in_tready,
  output logic               out_tvalid
);

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_LOAD = 13'h0002,
    S_READ = 13'h0004,
    S_ICLR = 13'h0008,
    S_IBLD = 13'h0010,
    S_ROOT = 13'h0020,
    S_QF   = 13'h0040,
    S_STEP = 13'h0080,
    S_REL  = 13'h0100,
    S_CMP  = 13'h0200,
    S_COPY = 13'h0400,
    S_FIN  = 13'h0800,
    S_RESP = 13'h1000
  } state_t;

  state_t state_r, state_nxt;
  logic   start_r, start_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fire;
  logic   go;

  assign go = !start_r && sts.done;

  always_comb begin
    state_nxt = state_r;
    fire      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_func)
            pcf_pkg::FUNC_LOAD:  state_nxt = S_LOAD;
            pcf_pkg::FUNC_CANON: state_nxt = S_ICLR;
            pcf_pkg::FUNC_READ:  state_nxt = S_READ;
            default:             state_nxt = S_RESP;
          endcase
        end
      end
      S_LOAD: if (go) state_nxt = S_RESP;
      S_READ: if (go) state_nxt = S_RESP;
      S_ICLR: if (go) state_nxt = S_IBLD;
      S_IBLD: if (go) state_nxt = S_ROOT;
      S_ROOT: if (go) state_nxt = S_QF;
      S_QF:   if (go) state_nxt = S_STEP;
      S_STEP: begin
        if (go) begin
          if (sts.more) state_nxt = S_QF;
          else if (!sts.complete) state_nxt = S_RESP;
          else state_nxt = S_REL;
        end
      end
      S_REL: if (go) state_nxt = S_CMP;
      S_CMP: begin
        if (go) begin
          if (sts.take) state_nxt = S_COPY;
          else if (sts.last_root) state_nxt = S_FIN;
          else state_nxt = S_ROOT;
        end
      end
      S_COPY: begin
        if (go) begin
          if (sts.last_root) state_nxt = S_FIN;
          else state_nxt = S_ROOT;
        end
      end
      S_FIN: if (go) state_nxt = S_RESP;
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          fire      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.start = start_r;
    unique case (state_r)
      S_LOAD:  cmd.op = pcf_pkg::OP_LOAD;
      S_READ:  cmd.op = pcf_pkg::OP_READ;
      S_ICLR:  cmd.op = pcf_pkg::OP_ICLR;
      S_IBLD:  cmd.op = pcf_pkg::OP_IBLD;
      S_ROOT:  cmd.op = pcf_pkg::OP_ROOT;
      S_QF:    cmd.op = pcf_pkg::OP_QFETCH;
      S_STEP:  cmd.op = pcf_pkg::OP_STEP;
      S_REL:   cmd.op = pcf_pkg::OP_RELABEL;
      S_CMP:   cmd.op = pcf_pkg::OP_CMP;
      S_COPY:  cmd.op = pcf_pkg::OP_COPY;
      S_FIN:   cmd.op = pcf_pkg::OP_FINAL;
      S_RESP:  cmd.op = fire ? pcf_pkg::OP_RESP : pcf_pkg::OP_NONE;
      default: cmd.op = pcf_pkg::OP_NONE;
    endcase
  end

  assign start_nxt     = (state_nxt != state_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign in_tready     = (state_r == S_IDLE);
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pcf_dpath.sv @@
// Datapath for the permutation tuple canonical form block: tuple, inverse,
// work, candidate and result memories, walk queue, labels and sweep counters.
// Depends on pcf_pkg; driven by pcf_ctrl.
`default_nettype none
module pcf_dpath #(
  parameter int POINTS = 23,
  parameter int PERMS  = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_accept,
  input  wire logic [2:0]    in_perm,
  input  wire logic [4:0]    in_point,
  input  wire logic [4:0]    in_image,
  input  wire pcf_pkg::cmd_t cmd,
  output pcf_pkg::sts_t      sts,
  output logic [4:0]         out_img,
  output logic               out_stat
);

  localparam int N     = PERMS * POINTS;
  localparam int AW    = $clog2(N);
  localparam int CW    = $clog2(N + 1);
  localparam int PTW   = $clog2(POINTS);
  localparam int NW    = $clog2(POINTS + 1);
  localparam int STEPS = 2 * PERMS;

  logic [PTW-1:0] tup_mem  [N];
  logic [PTW-1:0] inv_mem  [N];
  logic [PTW-1:0] work_mem [N];
  logic [PTW-1:0] cand_mem [N];
  logic [PTW-1:0] best_mem [N];
  logic [PTW-1:0] lab_mem  [POINTS];
  logic [PTW-1:0] que_mem  [POINTS];

  logic [PTW-1:0] tup_q, inv_q, work_q, cand_q, best_q, lab_qa, lab_qb, que_q;

  logic [AW-1:0]     addr_r;
  logic              inr_r;
  logic [PTW-1:0]    img_r;
  logic              best_valid_r, have_r;
  logic [CW-1:0]     cnt_r, kb_r, a1_r, kb1_r, kb2_r;
  logic [PTW-1:0]    pp_r, p1_r;
  logic              v1_r, v2_r, d1_r;
  logic [NW-1:0]     root_r, next_r, head_r;
  logic [PTW-1:0]    x_r;
  logic [POINTS-1:0] labeled_r;
  logic              cmp_done_r, cmp_less_r;
  logic [PTW-1:0]    pend_img_r;
  logic              pend_stat_r;
  logic [4:0]        out_img_r;
  logic              out_stat_r;

  function automatic logic [PTW-1:0] sat(input logic [PTW-1:0] v);
    sat = (32'(v) >= POINTS) ? PTW'(POINTS - 1) : v;
  endfunction

  logic           act, sweep_op, issue, new_lab;
  logic [CW-1:0]  lim, step_a, rd_a, ibld_a, rel_a;
  logic [PTW-1:0] ysat, tsat;

  assign act      = !cmd.start;
  assign sweep_op = (cmd.op == pcf_pkg::OP_ICLR) || (cmd.op == pcf_pkg::OP_IBLD) ||
                    (cmd.op == pcf_pkg::OP_STEP) || (cmd.op == pcf_pkg::OP_RELABEL) ||
                    (cmd.op == pcf_pkg::OP_CMP) || (cmd.op == pcf_pkg::OP_COPY) ||
                    (cmd.op == pcf_pkg::OP_FINAL);
  assign lim      = (cmd.op == pcf_pkg::OP_STEP) ? CW'(STEPS) : CW'(N);
  assign issue    = act && sweep_op && (cnt_r < lim);
  assign step_a   = kb_r + CW'(x_r);
  assign rd_a     = (cmd.op == pcf_pkg::OP_STEP) ? step_a : cnt_r;
  assign ibld_a   = kb1_r + CW'(tup_q);
  assign rel_a    = kb2_r + CW'(lab_qa);
  assign ysat     = sat(d1_r ? inv_q : tup_q);
  assign tsat     = sat(tup_q);
  assign new_lab  = act && (cmd.op == pcf_pkg::OP_STEP) && v1_r && !labeled_r[ysat];

  // memory reads, registered
  always_ff @(posedge clk) begin
    tup_q  <= tup_mem[rd_a[AW-1:0]];
    inv_q  <= inv_mem[rd_a[AW-1:0]];
    work_q <= work_mem[cnt_r[AW-1:0]];
    cand_q <= cand_mem[cnt_r[AW-1:0]];
    best_q <= best_mem[addr_r];
    lab_qa <= lab_mem[p1_r];
    lab_qb <= lab_mem[tsat];
    que_q  <= que_mem[head_r[PTW-1:0]];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (act && (cmd.op == pcf_pkg::OP_LOAD) && inr_r) tup_mem[addr_r] <= img_r;
  end

  always_ff @(posedge clk) begin
    if (issue && (cmd.op == pcf_pkg::OP_ICLR)) begin
      inv_mem[cnt_r[AW-1:0]] <= '0;
    end else if (act && (cmd.op == pcf_pkg::OP_IBLD) && v1_r && (32'(tup_q) < POINTS)) begin
      inv_mem[ibld_a[AW-1:0]] <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (act && (cmd.op == pcf_pkg::OP_RELABEL) && v2_r) work_mem[rel_a[AW-1:0]] <= lab_qb;
  end

  always_ff @(posedge clk) begin
    if (act && (cmd.op == pcf_pkg::OP_COPY) && v1_r) cand_mem[a1_r[AW-1:0]] <= work_q;
  end

  always_ff @(posedge clk) begin
    if (act && (cmd.op == pcf_pkg::OP_FINAL) && v1_r) best_mem[a1_r[AW-1:0]] <= cand_q;
  end

  always_ff @(posedge clk) begin
    if (act && (cmd.op == pcf_pkg::OP_ROOT)) begin
      lab_mem[root_r[PTW-1:0]] <= '0;
    end else if (new_lab) begin
      lab_mem[ysat] <= next_r[PTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (act && (cmd.op == pcf_pkg::OP_ROOT)) begin
      que_mem[0] <= root_r[PTW-1:0];
    end else if (new_lab) begin
      que_mem[next_r[PTW-1:0]] <= ysat;
    end
  end

  // status
  always_comb begin
    sts.more      = (head_r < next_r);
    sts.complete  = (next_r == NW'(POINTS));
    sts.take      = !have_r || cmp_less_r;
    sts.last_root = (root_r == NW'(POINTS));
    case (cmd.op)
      pcf_pkg::OP_LOAD, pcf_pkg::OP_READ,
      pcf_pkg::OP_ROOT, pcf_pkg::OP_QFETCH: sts.done = 1'b1;
      pcf_pkg::OP_ICLR:    sts.done = (cnt_r == CW'(N));
      pcf_pkg::OP_STEP:    sts.done = (cnt_r == CW'(STEPS)) && !v1_r;
      pcf_pkg::OP_RELABEL: sts.done = (cnt_r == CW'(N)) && !v1_r && !v2_r;
      pcf_pkg::OP_CMP:     sts.done = cmp_done_r || ((cnt_r == CW'(N)) && !v1_r);
      pcf_pkg::OP_IBLD, pcf_pkg::OP_COPY,
      pcf_pkg::OP_FINAL:   sts.done = (cnt_r == CW'(N)) && !v1_r;
      default:             sts.done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      have_r       <= 1'b0;
      cnt_r        <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      cmp_done_r   <= 1'b0;
      cmp_less_r   <= 1'b0;
      pend_stat_r  <= 1'b0;
      out_stat_r   <= 1'b0;
      root_r       <= '0;
      next_r       <= '0;
      head_r       <= '0;
    end else begin
      if (in_accept) begin
        addr_r      <= AW'(32'(in_perm) * POINTS + 32'(in_point));
        inr_r       <= (32'(in_perm) < PERMS) && (32'(in_point) < POINTS);
        img_r       <= (32'(in_image) >= POINTS) ? PTW'(POINTS - 1) : PTW'(in_image);
        pend_img_r  <= '0;
        pend_stat_r <= 1'b0;
      end
      if (cmd.op == pcf_pkg::OP_RESP) begin
        out_img_r  <= 5'(pend_img_r);
        out_stat_r <= pend_stat_r;
      end
      if (cmd.start) begin
        cnt_r      <= '0;
        pp_r       <= '0;
        kb_r       <= '0;
        v1_r       <= 1'b0;
        v2_r       <= 1'b0;
        cmp_done_r <= 1'b0;
        cmp_less_r <= 1'b0;
        if (cmd.op == pcf_pkg::OP_ICLR) begin
          root_r <= '0;
          have_r <= 1'b0;
        end
      end else begin
        v1_r  <= issue;
        v2_r  <= v1_r && (cmd.op == pcf_pkg::OP_RELABEL);
        kb2_r <= kb1_r;
        if (issue) begin
          cnt_r <= cnt_r + 1'b1;
          a1_r  <= cnt_r;
          p1_r  <= pp_r;
          kb1_r <= kb_r;
          d1_r  <= cnt_r[0];
          if (cmd.op == pcf_pkg::OP_STEP) begin
            if (cnt_r[0]) kb_r <= kb_r + CW'(POINTS);
          end else if (pp_r == PTW'(POINTS - 1)) begin
            pp_r <= '0;
            kb_r <= kb_r + CW'(POINTS);
          end else begin
            pp_r <= pp_r + 1'b1;
          end
        end
        case (cmd.op)
          pcf_pkg::OP_ROOT: begin
            labeled_r <= {{(POINTS-1){1'b0}}, 1'b1} << root_r[PTW-1:0];
            next_r    <= NW'(1);
            head_r    <= '0;
            root_r    <= root_r + 1'b1;
          end
          pcf_pkg::OP_QFETCH: begin
            x_r    <= que_q;
            head_r <= head_r + 1'b1;
          end
          pcf_pkg::OP_STEP: begin
            if (new_lab) begin
              labeled_r[ysat] <= 1'b1;
              next_r          <= next_r + 1'b1;
            end
            if (sts.done && !sts.more && !sts.complete) pend_stat_r <= 1'b1;
          end
          pcf_pkg::OP_CMP: begin
            if (v1_r && !cmp_done_r && (work_q != cand_q)) begin
              cmp_done_r <= 1'b1;
              cmp_less_r <= (work_q < cand_q);
            end
          end
          pcf_pkg::OP_COPY: begin
            if (sts.done) have_r <= 1'b1;
          end
          pcf_pkg::OP_FINAL: begin
            if (sts.done) best_valid_r <= 1'b1;
          end
          pcf_pkg::OP_READ: begin
            pend_img_r <= (inr_r && best_valid_r) ? best_q : '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_img  = out_img_r;
  assign out_stat = out_stat_r;

endmodule
`default_nettype wire

@@ rtl/core/permutation_tuple_canonical_form.sv @@
// Top level of the permutation tuple canonical form block.
// Joins pcf_ctrl and pcf_dpath; depends on pcf_pkg.
//
// Input channel in_*: one word per command. func 0 loads one tuple entry,
// func 1 canonicalizes the stored tuple, func 2 reads one canonical entry.
// Output channel out_*: exactly one result word per command, in order.
// One command is in progress at a time; in_tready is high only when idle,
// and a new word is taken while the last result still waits on out_*.
// Canonicalize clears and builds the inverse, then for each root runs the
// breadth-first walk, relabel, compare and copy sweeps, and ends with a final
// copy into the result memory; the breadth-first walk, relabel, compare and
// copy sweeps each move one entry per cycle. A nontransitive tuple ends at
// the first root whose walk misses a point.
// Reset clears the controller, the output valid and the result-valid flag;
// memory contents are undefined until loaded. When out_tready is low the
// result word holds and the next command waits in the response state.
`default_nettype none
module permutation_tuple_canonical_form #(
  parameter int POINTS = 23,
  parameter int PERMS  = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // func[1:0], perm_index[4:2], point[9:5], image[14:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // read_image[4:0], status[5]
);

  pcf_pkg::cmd_t cmd;
  pcf_pkg::sts_t sts;
  logic          in_accept;
  logic [4:0]    out_img;
  logic          out_stat;

  assign in_accept = in_tvalid && in_tready;

  pcf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_func    (in_tdata[1:0]),
    .sts        (sts),
    .out_tready (out_tready),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  pcf_dpath #(
    .POINTS (POINTS),
    .PERMS  (PERMS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_perm   (in_tdata[4:2]),
    .in_point  (in_tdata[9:5]),
    .in_image  (in_tdata[14:10]),
    .cmd       (cmd),
    .sts       (sts),
    .out_img   (out_img),
    .out_stat  (out_stat)
  );

  assign out_tdata = {2'b00, out_stat, out_img};

endmodule
`default_nettype wire

@@ rtl/core/pcf_chk.sv @@
// Port-level checker for the permutation tuple canonical form block.
// Watches the top level's ports only; attached by the bind below.
`default_nettype none
module pcf_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [15:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed under stall");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command word taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4:0] == 5'd0)
    else $error("nontransitive result carries an image");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind permutation_tuple_canonical_form pcf_chk u_pcf_chk (.*);
`default_nettype wire

@@ tb/permutation_tuple_canonical_form_chk.sv @@
// Checker for the permutation tuple canonical form block: watches both streams,
// predicts each result word and compares it with what comes out.
// Depends on pcf_pkg.
module permutation_tuple_canonical_form_chk #(
  parameter int POINTS = 23,
  parameter int PERMS  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       status;
    logic [4:0] read_image;
  } canon_word_t;

  canon_word_t expected_words[$];
  logic [4:0]  tuple_img[PERMS][POINTS];
  logic [4:0]  inv_img[PERMS][POINTS];
  logic [4:0]  canon_img[PERMS][POINTS];
  logic [4:0]  trial_img[PERMS][POINTS];
  logic [4:0]  keep_img[PERMS][POINTS];
  logic        canon_ok;

  initial errors = 0;
  assign pending = expected_words.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Relabel from every root; returns 1 when the tuple is transitive.
  function automatic logic relabel_all();
    int  lab[POINTS];
    bit  seen[POINTS];
    int  walk[POINTS];
    int  head, tail, nxt, x, y, cmp;
    bit  have;
    for (int k = 0; k < PERMS; k++) begin
      for (int i = 0; i < POINTS; i++) inv_img[k][i] = '0;
      for (int i = 0; i < POINTS; i++) inv_img[k][tuple_img[k][i]] = 5'(i);
    end
    have = 0;
    for (int r = 0; r < POINTS; r++) begin
      foreach (seen[i]) begin
        seen[i] = 0;
        lab[i] = 0;
      end
      seen[r] = 1;
      walk[0] = r;
      head = 0;
      tail = 1;
      nxt = 1;
      while (head < tail) begin
        x = walk[head++];
        for (int k = 0; k < PERMS; k++) begin
          for (int d = 0; d < 2; d++) begin
            y = d ? inv_img[k][x] : tuple_img[k][x];
            if (y >= POINTS) y = POINTS - 1;
            if (!seen[y] && tail < POINTS) begin
              seen[y] = 1;
              lab[y] = nxt++;
              walk[tail++] = y;
            end
          end
        end
      end
      if (nxt != POINTS) return 0;
      for (int k = 0; k < PERMS; k++)
        for (int p = 0; p < POINTS; p++)
          trial_img[k][lab[p]] = 5'(lab[tuple_img[k][p]]);
      cmp = 0;
      for (int k = 0; k < PERMS && cmp == 0; k++)
        for (int p = 0; p < POINTS && cmp == 0; p++)
          if (trial_img[k][p] != keep_img[k][p])
            cmp = trial_img[k][p] < keep_img[k][p] ? -1 : 1;
      if (!have || cmp < 0) begin
        keep_img = trial_img;
        have = 1;
      end
    end
    canon_img = keep_img;
    canon_ok = 1;
    return 1;
  endfunction

  always @(posedge clk) begin
    canon_word_t got, want;
    logic [2:0] pi;
    logic [4:0] pt, im;
    logic       in_range;
    if (!rst_n) begin
      canon_ok = 0;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = canon_word_t'(out_tdata[5:0]);
        if (expected_words.size() == 0) begin
          report("unexpected result word", out_tdata, 0);
        end else begin
          want = expected_words.pop_front();
          if (got.read_image != want.read_image)
            report("read_image", got.read_image, want.read_image);
          if (got.status != want.status) report("status", got.status, want.status);
          if (out_tdata[7:6] != 2'b00) report("pad bits", out_tdata[7:6], 0);
        end
      end
      if (in_tvalid && in_tready) begin
        pi = in_tdata[4:2];
        pt = in_tdata[9:5];
        im = in_tdata[14:10];
        in_range = pi < PERMS && pt < POINTS;
        want = '0;
        case (pcf_pkg::func_t'(in_tdata[1:0]))
          pcf_pkg::FUNC_LOAD: begin
            if (in_range) tuple_img[pi][pt] = im >= POINTS ? 5'(POINTS - 1) : im;
          end
          pcf_pkg::FUNC_CANON: want.status = !relabel_all();
          pcf_pkg::FUNC_READ: begin
            if (in_range && canon_ok) want.read_image = canon_img[pi][pt];
          end
          default: ;
        endcase
        expected_words.insert(expected_words.size(), want);
      end
    end
  end
endmodule

@@ tb/permutation_tuple_canonical_form_tb.sv @@
// Testbench top for the permutation tuple canonical form block: drives load,
// canonicalize and read words with random gaps and stalls, gives the verdict.
// Depends on pcf_pkg, the block and permutation_tuple_canonical_form_chk.
module permutation_tuple_canonical_form_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POINTS = 23;
  localparam int PERMS  = 5;
  localparam int IDLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // func[1:0], perm_index[4:2], point[9:5], image[14:10]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // read_image[4:0], status[5]
  int          errors;
  int          pending;
  int          idle_cycles;
  int          send_gaps;
  bit          hold_off;
  logic [4:0]  next_tuple[PERMS][POINTS];

  permutation_tuple_canonical_form #(.POINTS(POINTS), .PERMS(PERMS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  permutation_tuple_canonical_form_chk #(.POINTS(POINTS), .PERMS(PERMS)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send(input pcf_pkg::func_t f, input int pi, input int pt, input int im);
    int gap;
    gap = send_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {1'b0, 5'(im), 5'(pt), 3'(pi), f};
    @(posedge clk iff in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic shuffle_points(input int k);
    int j;
    logic [4:0] t;
    for (int i = 0; i < POINTS; i++) next_tuple[k][i] = 5'(i);
    for (int i = POINTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = next_tuple[k][i];
      next_tuple[k][i] = next_tuple[k][j];
      next_tuple[k][j] = t;
    end
  endtask

  // shape 0 random, 1 split in two orbits, 2 one long cycle, 3 broken entries
  task automatic build_tuple(input int shape);
    int h;
    for (int k = 0; k < PERMS; k++) begin
      shuffle_points(k);
      if (shape == 1) begin
        h = 11;
        for (int i = 0; i < POINTS; i++)
          next_tuple[k][i] = i < h ? 5'((i + k + 1) % h) : 5'(h + (i - h + k) % (POINTS - h));
      end else if (shape == 2) begin
        for (int i = 0; i < POINTS; i++)
          next_tuple[k][i] = k == 0 ? 5'((i + 1) % POINTS) : 5'(i);
      end else if (shape == 3) begin
        for (int n = 0; n < 3; n++) next_tuple[k][$urandom_range(0, POINTS - 1)] =
          5'($urandom_range(0, 31));
      end
    end
  endtask

  task automatic noise();
    case ($urandom_range(0, 2))
      0: send(pcf_pkg::FUNC_READ, $urandom_range(0, 7), $urandom_range(0, 31),
              $urandom_range(0, 31));
      1: send(pcf_pkg::FUNC_NOP, $urandom_range(0, 7), $urandom_range(0, 31),
              $urandom_range(0, 31));
      default: send(pcf_pkg::FUNC_LOAD, $urandom_range(PERMS, 7), $urandom_range(0, 31),
                    $urandom_range(0, 31));
    endcase
  endtask

  task automatic run_job(input int shape, input int n_reads);
    int order[PERMS * POINTS];
    int j, t, e;
    build_tuple(shape);
    foreach (order[i]) order[i] = i;
    for (int i = PERMS * POINTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    send_gaps = $urandom_range(0, 2);
    foreach (order[i]) begin
      e = order[i];
      if ($urandom_range(0, 9) == 0) noise();
      if (i == 40 && $urandom_range(0, 1)) hold_off = 1;
      send(pcf_pkg::FUNC_LOAD, e / POINTS, e % POINTS, next_tuple[e / POINTS][e % POINTS]);
    end
    if ($urandom_range(0, 1)) drain();
    send(pcf_pkg::FUNC_CANON, $urandom_range(0, 7), $urandom_range(0, 31),
         $urandom_range(0, 31));
    for (int i = 0; i < n_reads; i++) begin
      if ($urandom_range(0, 7) == 0) noise();
      else send(pcf_pkg::FUNC_READ, $urandom_range(0, PERMS - 1),
                $urandom_range(0, POINTS - 1), 0);
    end
  endtask

  initial begin
    int hold;
    out_tready = 0;
    wait (rst_n);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        out_tready <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_tready <= 0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
    end
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    send_gaps = 0;
    hold_off = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(pcf_pkg::FUNC_READ, 0, 0, 0);
    send(pcf_pkg::FUNC_READ, PERMS - 1, POINTS - 1, 31);
    send(pcf_pkg::FUNC_READ, 7, 31, 31);
    send(pcf_pkg::FUNC_NOP, 7, 31, 31);
    send(pcf_pkg::FUNC_NOP, 0, 0, 0);
    send(pcf_pkg::FUNC_LOAD, 7, 0, 31);
    send(pcf_pkg::FUNC_LOAD, 0, 31, 31);
    send(pcf_pkg::FUNC_LOAD, 5, 23, 0);
    hold_off = 1;
    run_job(2, 20);
    send(pcf_pkg::FUNC_READ, 0, 0, 0);
    send(pcf_pkg::FUNC_READ, PERMS - 1, POINTS - 1, 0);
    send(pcf_pkg::FUNC_READ, 7, 31, 0);
    drain();
    for (int job = 0; job < 7; job++) run_job(job % 4, 45);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
